// ===== rtl/sqam_pkg.sv =====
`timescale 1ns / 1ps
// Constants, register codes and the quarter-wave sine table of the square QAM modulator.
package sqam_pkg;

  localparam int MAX_SAMPLES      = 64;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int PHASE_BITS       = 16;

  localparam int TAB_BITS = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER  = SINE_TABLE_DEPTH / 4;
  localparam int QTR_BITS = TAB_BITS - 2;
  localparam int R_SHIFT  = 30 - QTR_BITS;
  localparam int CNT_BITS = $clog2(MAX_SAMPLES);

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned Q30_HALF    = 64'd536870912;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_AMP   = 2'd1;
  localparam logic [1:0] REG_STEP  = 2'd2;
  localparam logic [1:0] REG_SPB   = 2'd3;

  localparam logic [1:0] ORDER_NONE  = 2'd0;
  localparam logic [1:0] ORDER_4QAM  = 2'd1;
  localparam logic [1:0] ORDER_16QAM = 2'd2;
  localparam logic [1:0] ORDER_64QAM = 2'd3;

  localparam logic [1:0]  ORDER_RESET = ORDER_16QAM;
  localparam logic [14:0] AMP_RESET   = 15'd16384;
  localparam logic [15:0] STEP_RESET  = 16'd4096;
  localparam logic [6:0]  SPB_RESET   = 7'd16;

  // Reciprocals for exact division by three and by seven of values below 2^19.
  localparam logic [21:0] DIV1_MUL = 22'd2097152;
  localparam logic [21:0] DIV3_MUL = 22'd699051;
  localparam logic [21:0] DIV7_MUL = 22'd599187;
  localparam logic [4:0]  DIV1_SH  = 5'd21;
  localparam logic [4:0]  DIV3_SH  = 5'd21;
  localparam logic [4:0]  DIV7_SH  = 5'd22;

  typedef logic [14:0] qsin_tab_t [0:QUARTER];

  function automatic logic [14:0] quarter_sine(int unsigned m);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint s;
    longint v;
    r    = longint'(m) << R_SHIFT;
    x    = (r * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    term = ((term * x2) >> 30) / 6;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 20;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 42;
    s    = s - longint'(term);
    term = ((term * x2) >> 30) / 72;
    s    = s + longint'(term);
    term = ((term * x2) >> 30) / 110;
    s    = s - longint'(term);
    if (s < 0) s = 0;
    v = (s * 32767 + longint'(Q30_HALF)) >>> 30;
    if (v > 32767) v = 32767;
    return v[14:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    for (int unsigned i = 0; i <= QUARTER; i++) begin
      tab[i] = quarter_sine(i);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN_TAB = build_qsin();

  function automatic logic signed [15:0] sine_lookup(logic [TAB_BITS-1:0] idx);
    logic [1:0]          quad;
    logic [QTR_BITS:0]   r;
    logic signed [15:0]  mag;
    quad = idx[TAB_BITS-1 -: 2];
    r    = quad[0] ? ((QTR_BITS+1)'(QUARTER) - {1'b0, idx[QTR_BITS-1:0]})
                   : {1'b0, idx[QTR_BITS-1:0]};
    mag  = signed'({1'b0, QSIN_TAB[r]});
    return quad[1] ? -mag : mag;
  endfunction

endpackage

// ===== rtl/sqam_level.sv =====
`timescale 1ns / 1ps
// Axis level of one constellation coordinate, A*(L-1-2k)/(L-1) rounded half up.
module sqam_level import sqam_pkg::*; (
  input  logic [1:0]         order,
  input  logic [2:0]         k,
  input  logic [14:0]        amp,
  output logic signed [15:0] level
);

  logic [2:0]  den;
  logic [21:0] mul;
  logic [4:0]  sh;
  logic        neg;
  logic [2:0]  mag_n;
  logic [17:0] prod;
  logic [17:0] x;
  logic [39:0] scaled;
  logic [14:0] q;

  always_comb begin
    unique case (order)
      ORDER_16QAM: begin
        den = 3'd3;
        mul = DIV3_MUL;
        sh  = DIV3_SH;
      end
      ORDER_64QAM: begin
        den = 3'd7;
        mul = DIV7_MUL;
        sh  = DIV7_SH;
      end
      default: begin
        den = 3'd1;
        mul = DIV1_MUL;
        sh  = DIV1_SH;
      end
    endcase
    neg    = {k, 1'b0} > {1'b0, den};
    mag_n  = neg ? 3'({k, 1'b0} - {1'b0, den}) : 3'({1'b0, den} - {k, 1'b0});
    prod   = 18'(mag_n) * 18'(amp);
    x      = prod + 18'(den >> 1);
    scaled = 40'(x) * 40'(mul);
    q      = 15'(scaled >> sh);
    level  = neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
  end

endmodule

// ===== rtl/square_qam_modulator_top.sv =====
`timescale 1ns / 1ps
// Top level of the square 4/16/64-QAM modulator.
//
// A symbol item enters on symbol/symbol_valid and is taken at a clock edge where
// symbol_stall is low. Each symbol yields samples_per_symbol sample items on
// sample/last/sample_valid, one per cycle while sample_stall is low, with last high on the final one; a value
// of zero gives one sample and values above 64 give 64.
// A symbol passes the holding register, the sample generator, the sine lookup and
// product registers and the output register. It waits in the holding register while
// the previous one is still being played out, so consecutive symbols run without
// gaps and the sample generator sets the pace.
// When the receiver stalls, the whole sample pipeline holds and symbol_stall rises
// once the holding register is occupied.
// Reset empties the pipeline and loads the registers with 16-QAM, amplitude 16384,
// phase step 4096 and sixteen samples per symbol.
// Registers lie at byte addresses 0, 4, 8 and 12 of the APB port and should be
// written only while no symbol is in flight.
module square_qam_modulator_top import sqam_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic [5:0]         symbol,
  input  logic               symbol_valid,
  output logic               symbol_stall,
  output logic signed [16:0] sample,
  output logic               last,
  output logic               sample_valid,
  input  logic               sample_stall
);

  logic [1:0]  order_sel;
  logic [14:0] amp;
  logic [15:0] step;
  logic [6:0]  spb;

  logic [1:0]  order_eff;
  logic [2:0]  ki;
  logic [2:0]  kq;
  logic signed [15:0] li;
  logic signed [15:0] lq;

  logic               lv_valid;
  logic signed [15:0] lv_i;
  logic signed [15:0] lv_q;

  logic               gen_valid;
  logic signed [15:0] gen_i;
  logic signed [15:0] gen_q;
  logic [CNT_BITS-1:0] gen_n;
  logic [CNT_BITS-1:0] gen_last_n;
  logic [PHASE_BITS-1:0] phase;

  logic               s1_valid;
  logic               s1_last;
  logic signed [15:0] s1_i;
  logic signed [15:0] s1_q;
  logic signed [15:0] s1_cos;
  logic signed [15:0] s1_sin;

  logic               s2_valid;
  logic               s2_last;
  logic signed [31:0] s2_pi;
  logic signed [31:0] s2_pq;

  logic                adv;
  logic                gen_end;
  logic                load;
  logic                take;
  logic                cfg_wr;
  logic [CNT_BITS-1:0] last_n_next;
  logic [TAB_BITS-1:0] sin_idx;
  logic [TAB_BITS-1:0] cos_idx;
  logic signed [32:0]  acc;
  logic signed [17:0]  shifted;
  logic signed [16:0]  sample_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    unique case (paddr[3:2])
      REG_ORDER: prdata = 32'(order_sel);
      REG_AMP:   prdata = 32'(amp);
      REG_STEP:  prdata = 32'(step);
      REG_SPB:   prdata = 32'(spb);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      order_sel <= ORDER_RESET;
      amp       <= AMP_RESET;
      step      <= STEP_RESET;
      spb       <= SPB_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ORDER: order_sel <= pwdata[1:0];
        REG_AMP:   amp       <= pwdata[14:0];
        REG_STEP:  step      <= pwdata[15:0];
        REG_SPB:   spb       <= pwdata[6:0];
      endcase
    end
  end

  assign order_eff = (order_sel == ORDER_NONE) ? ORDER_4QAM : order_sel;

  always_comb begin
    unique case (order_eff)
      ORDER_16QAM: begin
        ki = {1'b0, symbol[3:2]};
        kq = {1'b0, symbol[1:0]};
      end
      ORDER_64QAM: begin
        ki = symbol[5:3];
        kq = symbol[2:0];
      end
      default: begin
        ki = {2'b00, symbol[1]};
        kq = {2'b00, symbol[0]};
      end
    endcase
  end

  sqam_level u_level_i (
    .order (order_eff),
    .k     (ki),
    .amp   (amp),
    .level (li)
  );

  sqam_level u_level_q (
    .order (order_eff),
    .k     (kq),
    .amp   (amp),
    .level (lq)
  );

  assign adv          = !sample_valid || !sample_stall;
  assign gen_end      = gen_n == gen_last_n;
  assign load         = adv && (!gen_valid || gen_end);
  assign symbol_stall = lv_valid && !load;
  assign take         = symbol_valid && !symbol_stall;

  always_comb begin
    if (spb == 7'd0) begin
      last_n_next = '0;
    end else if (spb > 7'(MAX_SAMPLES)) begin
      last_n_next = CNT_BITS'(MAX_SAMPLES - 1);
    end else begin
      last_n_next = CNT_BITS'(spb - 7'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lv_valid <= 1'b0;
    end else if (take) begin
      lv_valid <= 1'b1;
    end else if (load) begin
      lv_valid <= 1'b0;
    end
    if (take) begin
      lv_i <= li;
      lv_q <= lq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen_valid <= 1'b0;
    end else if (load) begin
      gen_valid <= lv_valid;
    end
    if (load) begin
      gen_i      <= lv_i;
      gen_q      <= lv_q;
      gen_n      <= '0;
      gen_last_n <= last_n_next;
      phase      <= '0;
    end else if (adv && gen_valid) begin
      gen_n <= gen_n + 1'b1;
      phase <= phase + step;
    end
  end

  assign sin_idx = phase[PHASE_BITS-1 -: TAB_BITS];
  assign cos_idx = sin_idx + TAB_BITS'(QUARTER);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= gen_valid;
      s2_valid <= s1_valid;
    end
    if (adv) begin
      s1_last <= gen_end;
      s1_i    <= gen_i;
      s1_q    <= gen_q;
      s1_sin  <= sine_lookup(sin_idx);
      s1_cos  <= sine_lookup(cos_idx);
      s2_last <= s1_last;
      s2_pi   <= s1_i * s1_cos;
      s2_pq   <= s1_q * s1_sin;
    end
  end

  always_comb begin
    acc     = 33'(s2_pi) + 33'(s2_pq) + 33'sd16384;
    shifted = 18'(acc >>> 15);
    if (shifted > 18'sd65535) begin
      sample_next = 17'sd65535;
    end else if (shifted < -18'sd65536) begin
      sample_next = -17'sd65536;
    end else begin
      sample_next = 17'(shifted);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (adv) begin
      sample_valid <= s2_valid;
    end
    if (adv) begin
      sample <= sample_next;
      last   <= s2_last;
    end
  end

endmodule

// ===== rtl/sqam_checker.sv =====
`timescale 1ns / 1ps
// Port checker for the square QAM modulator, bound to the top level.
module sqam_checker (
  input logic               clk,
  input logic               rst,
  input logic               symbol_valid,
  input logic               symbol_stall,
  input logic signed [16:0] sample,
  input logic               last,
  input logic               sample_valid,
  input logic               sample_stall
);

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    sample_valid && sample_stall |=> sample_valid && $stable(sample) && $stable(last))
    else $error("stalled sample item changed");

  a_reset_stall: assert property (@(posedge clk)
    rst |=> !symbol_stall)
    else $error("symbol stall raised straight after reset");

  a_reset_latency: assert property (@(posedge clk)
    rst |=> !sample_valid ##1 !sample_valid ##1 !sample_valid ##1 !sample_valid)
    else $error("sample item appeared sooner than the pipeline allows");

endmodule

bind square_qam_modulator_top sqam_checker u_sqam_checker (.*);

// ===== tb/square_qam_modulator_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the square QAM modulator: symbols in, predicted waveform samples out.
module square_qam_modulator_top_tb;
  import sqam_pkg::*;

  typedef struct {
    logic signed [16:0] sample;
    logic               last;
  } wave_sample_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic [5:0]         symbol = '0;
  logic               symbol_valid = 1'b0;
  logic               symbol_stall;
  logic signed [16:0] sample;
  logic               last;
  logic               sample_valid;
  logic               sample_stall = 1'b0;

  logic [1:0]  cfg_order = ORDER_RESET;
  logic [14:0] cfg_amp = AMP_RESET;
  logic [15:0] cfg_step = STEP_RESET;
  logic [6:0]  cfg_spb = SPB_RESET;

  int           carrier_sine [SINE_TABLE_DEPTH];
  wave_sample_t pending_samples [$];
  int           errors = 0;
  bit           quiet_tail = 1'b0;
  bit           stall_now = 1'b0;
  int           burst_left = 0;

  localparam logic [1:0] ORDER_CODES [4] = '{ORDER_NONE, ORDER_4QAM, ORDER_16QAM, ORDER_64QAM};

  square_qam_modulator_top dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .sample       (sample),
    .last         (last),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall)
  );

  always #5 clk = ~clk;

  function automatic int sine_entry(int unsigned n);
    longint unsigned p;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint          s;
    longint          v;
    int unsigned     quad;
    p    = (longint'(n) << 32) / SINE_TABLE_DEPTH;
    quad = int'((p >> 30) & 3);
    r    = p & 64'h3FFF_FFFF;
    if (quad[0]) r = 64'h4000_0000 - r;
    x    = (r * 64'd1686629713) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    s    = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k % 2 == 1) s = s - longint'(term);
      else s = s + longint'(term);
    end
    if (s < 0) s = 0;
    v = (s * 32767 + 64'd536870912) >>> 30;
    if (v > 32767) v = 32767;
    return quad[1] ? -int'(v) : int'(v);
  endfunction

  function automatic longint axis_level(int unsigned k, int unsigned levels);
    longint num;
    longint den;
    longint mag;
    longint q;
    num = longint'(levels) - 1 - 2 * longint'(k);
    den = longint'(levels) - 1;
    mag = (num < 0 ? -num : num) * longint'(cfg_amp);
    q   = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  task automatic predict_waveform(input logic [5:0] sym);
    int unsigned  b;
    int unsigned  levels;
    int unsigned  count;
    int unsigned  idx;
    int unsigned  cidx;
    logic [15:0]  phase;
    longint       li;
    longint       lq;
    longint       acc;
    longint       sv;
    wave_sample_t want;
    b      = (cfg_order == ORDER_NONE) ? 1 : int'(cfg_order);
    levels = 1 << b;
    li     = axis_level((int'(sym) >> b) & (levels - 1), levels);
    lq     = axis_level(int'(sym) & (levels - 1), levels);
    count  = cfg_spb;
    if (count == 0) count = 1;
    if (count > MAX_SAMPLES) count = MAX_SAMPLES;
    for (int unsigned n = 0; n < count; n++) begin
      phase = n * cfg_step;
      idx   = int'((longint'(phase) * SINE_TABLE_DEPTH) >> PHASE_BITS) % SINE_TABLE_DEPTH;
      cidx  = (idx + SINE_TABLE_DEPTH / 4) % SINE_TABLE_DEPTH;
      acc   = li * carrier_sine[cidx] + lq * carrier_sine[idx];
      sv    = (acc + 16384) >>> 15;
      if (sv > 65535) sv = 65535;
      if (sv < -65536) sv = -65536;
      want.sample = sv[16:0];
      want.last   = (n + 1 == count);
      pending_samples.insert(pending_samples.size(), want);
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    wave_sample_t want;
    if (!rst && sample_valid && !sample_stall) begin
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d with no symbol outstanding", sample));
      end else begin
        want = pending_samples.pop_front();
        if (sample !== want.sample)
          report_mismatch($sformatf("sample %0d, expected %0d", sample, want.sample));
        if (last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", last, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || quiet_tail) begin
      stall_now  = 1'b0;
      burst_left = 0;
    end else begin
      if (burst_left == 0) begin
        stall_now = ($urandom_range(0, 2) == 0);
        if (stall_now) burst_left = $urandom_range(1, 13);
        else if ($urandom_range(0, 9) == 0) burst_left = 200;
        else burst_left = $urandom_range(1, 40);
      end
      burst_left--;
    end
    sample_stall <= stall_now;
  end

  task automatic apb_write(input logic [1:0] reg_idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (reg_idx)
      REG_ORDER: cfg_order = value[1:0];
      REG_AMP:   cfg_amp = value[14:0];
      REG_STEP:  cfg_step = value[15:0];
      REG_SPB:   cfg_spb = value[6:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] order, input logic [31:0] amp,
                            input logic [31:0] step, input logic [31:0] spb);
    apb_write(REG_ORDER, order);
    apb_write(REG_AMP, amp);
    apb_write(REG_STEP, step);
    apb_write(REG_SPB, spb);
  endtask

  task automatic send_symbol(input logic [5:0] sym);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      symbol_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    symbol       <= sym;
    symbol_valid <= 1'b1;
    do @(posedge clk); while (symbol_stall);
    predict_waveform(sym);
  endtask

  task automatic drain;
    symbol_valid <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_reset_defaults;
    send_symbol(6'd0);
    send_symbol(6'd15);
    send_symbol(6'd9);
    drain();
  endtask

  task automatic test_orders;
    apb_write(REG_SPB, 32'd3);
    apb_write(REG_STEP, 32'd16384);
    foreach (ORDER_CODES[i]) begin
      apb_write(REG_ORDER, {30'd0, ORDER_CODES[i]});
      send_symbol(6'd0);
      send_symbol(6'd63);
      send_symbol(6'b100110);
      drain();
    end
  endtask

  task automatic test_amplitude_and_step;
    set_config({30'd0, ORDER_64QAM}, 32'd32767, 32'd65535, 32'd5);
    send_symbol(6'd0);
    send_symbol(6'd63);
    drain();
    set_config({30'd0, ORDER_16QAM}, 32'd0, 32'd0, 32'd4);
    send_symbol(6'd21);
    send_symbol(6'd42);
    drain();
  endtask

  task automatic test_sample_counts;
    apb_write(REG_SPB, 32'd0);
    send_symbol(6'd5);
    drain();
    apb_write(REG_SPB, 32'd1);
    send_symbol(6'd50);
    drain();
    apb_write(REG_SPB, 32'd64);
    send_symbol(6'd27);
    drain();
    set_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_symbol(6'd36);
    drain();
  endtask

  task automatic test_random_traffic;
    logic [31:0] amp;
    logic [31:0] step;
    logic [31:0] spb;
    for (int phase_no = 0; phase_no < 5; phase_no++) begin
      case ($urandom_range(0, 3))
        0: amp = 32'd0;
        1: amp = 32'd32767;
        default: amp = $urandom_range(0, 32767);
      endcase
      case ($urandom_range(0, 3))
        0: step = 32'd0;
        1: step = 32'd65535;
        default: step = $urandom_range(0, 65535);
      endcase
      if (phase_no == 3) spb = 32'd64;
      else if ($urandom_range(0, 4) == 0) spb = $urandom_range(0, 127);
      else spb = $urandom_range(1, 16);
      set_config({30'd0, ORDER_CODES[$urandom_range(0, 3)]}, amp, step, spb);
      if (phase_no == 4) quiet_tail = 1'b1;
      for (int i = 0; i < 50; i++) begin
        if (phase_no == 1 && i == 25) begin
          symbol_valid <= 1'b0;
          while (pending_samples.size() != 0) @(posedge clk);
        end
        send_symbol(6'($urandom_range(0, 63)));
      end
      drain();
    end
  endtask

  initial begin
    for (int n = 0; n < SINE_TABLE_DEPTH; n++) carrier_sine[n] = sine_entry(n);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_orders();
    test_amplitude_and_step();
    test_sample_counts();
    test_random_traffic();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
